[rtl/aat_pkg.sv]
package aat_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 31;
  localparam int ROW_W     = 2;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_AXES  = 3;
  localparam int ROW_TRANS = 3;

  // Full product, rounded product and column sum widths
  localparam int PROD_W = 2 * WORD_W;
  localparam int QW     = PROD_W - FRAC_BITS;
  localparam int SW     = QW + 2;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  // Stream payload sizes, padded to whole bytes
  localparam int IN_FIELDS_W  = ROW_W + 6 * WORD_W + 3 * HALF_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = 3 * WORD_W + 3 * HALF_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic {
    KIND_ROW_LOAD = 1'b0,
    KIND_BOX      = 1'b1
  } kind_t;

  // Packed structs list the top bits first: the last field ends up at bit 0
  typedef struct packed {
    logic [IN_PAD_W-1:0]      pad;
    logic [HALF_W-1:0]        box_half_z;
    logic [HALF_W-1:0]        box_half_y;
    logic [HALF_W-1:0]        box_half_x;
    logic signed [WORD_W-1:0] box_center_z;
    logic signed [WORD_W-1:0] box_center_y;
    logic signed [WORD_W-1:0] box_center_x;
    logic signed [WORD_W-1:0] row_z;
    logic signed [WORD_W-1:0] row_y;
    logic signed [WORD_W-1:0] row_x;
    logic [ROW_W-1:0]         row_index;
  } in_data_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]     pad;
    logic [HALF_W-1:0]        world_half_z;
    logic [HALF_W-1:0]        world_half_y;
    logic [HALF_W-1:0]        world_half_x;
    logic signed [WORD_W-1:0] world_center_z;
    logic signed [WORD_W-1:0] world_center_y;
    logic signed [WORD_W-1:0] world_center_x;
  } out_data_t;

  typedef struct packed {
    logic                     clip;
    logic signed [WORD_W-1:0] val;
  } sat_t;

  // Clamp a wide signed value to the 32-bit word range
  function automatic sat_t sat_word(input logic signed [SW-1:0] v);
    sat_t r;
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[SW-1] && (|v[SW-2:WORD_W-1]);
    neg_ovf = v[SW-1] && !(&v[SW-2:WORD_W-1]);
    r.clip  = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      r.val = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (neg_ovf) begin
      r.val = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r.val = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/aat_col_range.sv]
// Rounds the six products of one matrix column and picks, per axis, the
// smaller and larger term. Each corner coordinate takes only its low or
// high value, so the column extreme is the sum of per-axis extremes.
module aat_col_range (
  input  logic signed [aat_pkg::PROD_W-1:0] prod_lo_i [aat_pkg::NUM_AXES],
  input  logic signed [aat_pkg::PROD_W-1:0] prod_hi_i [aat_pkg::NUM_AXES],
  output logic signed [aat_pkg::QW-1:0]     min_term_o [aat_pkg::NUM_AXES],
  output logic signed [aat_pkg::QW-1:0]     max_term_o [aat_pkg::NUM_AXES]
);

  logic signed [aat_pkg::PROD_W-1:0] rnd_lo [aat_pkg::NUM_AXES];
  logic signed [aat_pkg::PROD_W-1:0] rnd_hi [aat_pkg::NUM_AXES];
  logic signed [aat_pkg::QW-1:0]     q_lo   [aat_pkg::NUM_AXES];
  logic signed [aat_pkg::QW-1:0]     q_hi   [aat_pkg::NUM_AXES];

  // Round half up, then floor shift by taking the upper bits
  always_comb begin
    for (int a = 0; a < aat_pkg::NUM_AXES; a++) begin
      rnd_lo[a] = prod_lo_i[a] + aat_pkg::ROUND_HALF;
      rnd_hi[a] = prod_hi_i[a] + aat_pkg::ROUND_HALF;
      q_lo[a]   = rnd_lo[a][aat_pkg::PROD_W-1:aat_pkg::FRAC_BITS];
      q_hi[a]   = rnd_hi[a][aat_pkg::PROD_W-1:aat_pkg::FRAC_BITS];
      if (q_lo[a] < q_hi[a]) begin
        min_term_o[a] = q_lo[a];
        max_term_o[a] = q_hi[a];
      end else begin
        min_term_o[a] = q_hi[a];
        max_term_o[a] = q_lo[a];
      end
    end
  end

endmodule

[rtl/aabb_affine_transform.sv]
// Channel | Direction | Carries
// in_     | input     | row load (tuser=0) or box (tuser=1), one per transaction
// out_    | output    | world box and saturation flag, one per box
//
// Throughput is one transaction per cycle while out_ is not stalled; a box result is offered
// once it has passed the input, product, term, extreme and output registers.
// The 18 32x32 products share their stage only with corner forming.
// Reset (synchronous, active low) empties the pipeline and clears the matrix.
// A row load writes the matrix as it leaves the input register, so every
// later box sees it. Stalls on out_ only block in_ once every stage is full.
module aabb_affine_transform (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row_index, row_x, row_y, row_z, box_center_x/y/z, box_half_x/y/z, pad
  input  logic [aat_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // world_center_x/y/z, world_half_x/y/z, pad
  output logic [aat_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // saturated
  output logic                               out_tuser
);

  localparam int NA = aat_pkg::NUM_AXES;
  localparam int WW = aat_pkg::WORD_W;

  // Stored matrix, [row][column]
  logic signed [WW-1:0] mat_r [aat_pkg::NUM_ROWS][NA];

  // Stage valids and handshake
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, out_v_nxt;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_box, s1_load;

  // Stage payloads
  aat_pkg::kind_t    s1_kind_r;
  aat_pkg::in_data_t s1_data_r;
  logic signed [aat_pkg::PROD_W-1:0] s2_prod_lo_r [NA][NA];
  logic signed [aat_pkg::PROD_W-1:0] s2_prod_hi_r [NA][NA];
  logic signed [WW-1:0]              s2_trans_r   [NA];
  logic                              s2_clip_r;
  logic signed [aat_pkg::QW-1:0]     s3_min_r     [NA][NA];
  logic signed [aat_pkg::QW-1:0]     s3_max_r     [NA][NA];
  logic signed [WW-1:0]              s3_trans_r   [NA];
  logic                              s3_clip_r;
  logic signed [WW-1:0]              s4_lo_r      [NA];
  logic signed [WW-1:0]              s4_hi_r      [NA];
  logic                              s4_clip_r;
  aat_pkg::out_data_t                out_data_r;
  logic                              out_sat_r;

  // Combinational values between stages
  logic signed [WW-1:0]              ctr     [NA];
  logic [aat_pkg::HALF_W-1:0]        hlf     [NA];
  aat_pkg::sat_t                     crn_lo  [NA];
  aat_pkg::sat_t                     crn_hi  [NA];
  logic                              crn_clip;
  logic signed [aat_pkg::PROD_W-1:0] prod_lo [NA][NA];
  logic signed [aat_pkg::PROD_W-1:0] prod_hi [NA][NA];
  logic signed [aat_pkg::QW-1:0]     min_term [NA][NA];
  logic signed [aat_pkg::QW-1:0]     max_term [NA][NA];
  logic signed [aat_pkg::SW-1:0]     sum_min [NA];
  logic signed [aat_pkg::SW-1:0]     sum_max [NA];
  aat_pkg::sat_t                     ext_lo  [NA];
  aat_pkg::sat_t                     ext_hi  [NA];
  logic                              ext_clip;
  logic signed [WW:0]                pair_sum  [NA];
  logic signed [WW:0]                pair_diff [NA];
  logic signed [WW-1:0]              w_ctr  [NA];
  logic [aat_pkg::HALF_W-1:0]        w_half [NA];
  aat_pkg::out_data_t                out_data_nxt;

  // Ready chain: a stage moves on when empty or when the next one moves
  assign out_rdy   = !out_v_r || out_tready;
  assign s4_rdy    = !s4_v_r || out_rdy;
  assign s3_rdy    = !s3_v_r || s4_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_box    = s1_v_r && (s1_kind_r == aat_pkg::KIND_BOX);
  assign s1_load   = s1_v_r && (s1_kind_r == aat_pkg::KIND_ROW_LOAD);
  assign in_tready = !s1_v_r || s1_load || s2_rdy;

  always_comb begin
    s1_v_nxt  = in_tready ? in_tvalid : s1_v_r;
    s2_v_nxt  = s2_rdy ? s1_box : s2_v_r;
    s3_v_nxt  = s3_rdy ? s2_v_r : s3_v_r;
    s4_v_nxt  = s4_rdy ? s3_v_r : s4_v_r;
    out_v_nxt = out_rdy ? s4_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      s4_v_r  <= s4_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Matrix store: a row load lands as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < aat_pkg::NUM_ROWS; r++) begin
        for (int j = 0; j < NA; j++) begin
          mat_r[r][j] <= '0;
        end
      end
    end else if (s1_load) begin
      mat_r[s1_data_r.row_index][0] <= s1_data_r.row_x;
      mat_r[s1_data_r.row_index][1] <= s1_data_r.row_y;
      mat_r[s1_data_r.row_index][2] <= s1_data_r.row_z;
    end
  end

  // Stage 1: low and high corner coordinate per axis, then the products
  always_comb begin
    ctr[0] = s1_data_r.box_center_x;
    ctr[1] = s1_data_r.box_center_y;
    ctr[2] = s1_data_r.box_center_z;
    hlf[0] = s1_data_r.box_half_x;
    hlf[1] = s1_data_r.box_half_y;
    hlf[2] = s1_data_r.box_half_z;
    crn_clip = 1'b0;
    for (int a = 0; a < NA; a++) begin
      crn_lo[a] = aat_pkg::sat_word(aat_pkg::SW'(ctr[a]) - aat_pkg::SW'($signed({1'b0, hlf[a]})));
      crn_hi[a] = aat_pkg::sat_word(aat_pkg::SW'(ctr[a]) + aat_pkg::SW'($signed({1'b0, hlf[a]})));
      crn_clip  = crn_clip | crn_lo[a].clip | crn_hi[a].clip;
      for (int j = 0; j < NA; j++) begin
        prod_lo[j][a] = crn_lo[a].val * mat_r[a][j];
        prod_hi[j][a] = crn_hi[a].val * mat_r[a][j];
      end
    end
  end

  // Stage 2: round and sort the terms, one column unit each
  for (genvar j = 0; j < NA; j++) begin : g_col
    aat_col_range u_col (
      .prod_lo_i  (s2_prod_lo_r[j]),
      .prod_hi_i  (s2_prod_hi_r[j]),
      .min_term_o (min_term[j]),
      .max_term_o (max_term[j])
    );
  end

  // Stage 3: column extremes, clamped to the word range
  always_comb begin
    ext_clip = 1'b0;
    for (int j = 0; j < NA; j++) begin
      sum_min[j] = aat_pkg::SW'(s3_trans_r[j]) + aat_pkg::SW'(s3_min_r[j][0])
                 + aat_pkg::SW'(s3_min_r[j][1]) + aat_pkg::SW'(s3_min_r[j][2]);
      sum_max[j] = aat_pkg::SW'(s3_trans_r[j]) + aat_pkg::SW'(s3_max_r[j][0])
                 + aat_pkg::SW'(s3_max_r[j][1]) + aat_pkg::SW'(s3_max_r[j][2]);
      ext_lo[j]  = aat_pkg::sat_word(sum_min[j]);
      ext_hi[j]  = aat_pkg::sat_word(sum_max[j]);
      ext_clip   = ext_clip | ext_lo[j].clip | ext_hi[j].clip;
    end
  end

  // Stage 4: world center and half-extent, both floor halves
  always_comb begin
    for (int j = 0; j < NA; j++) begin
      pair_sum[j]  = (WW+1)'(s4_lo_r[j]) + (WW+1)'(s4_hi_r[j]);
      pair_diff[j] = (WW+1)'(s4_hi_r[j]) - (WW+1)'(s4_lo_r[j]);
      w_ctr[j]     = pair_sum[j][WW:1];
      w_half[j]    = pair_diff[j][aat_pkg::HALF_W:1];
    end
    out_data_nxt.pad            = '0;
    out_data_nxt.world_center_x = w_ctr[0];
    out_data_nxt.world_center_y = w_ctr[1];
    out_data_nxt.world_center_z = w_ctr[2];
    out_data_nxt.world_half_x   = w_half[0];
    out_data_nxt.world_half_y   = w_half[1];
    out_data_nxt.world_half_z   = w_half[2];
  end

  // Payload registers, loaded when the stage takes a transaction
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= aat_pkg::kind_t'(in_tuser);
      s1_data_r <= aat_pkg::in_data_t'(in_tdata);
    end
    if (s1_box && s2_rdy) begin
      s2_prod_lo_r <= prod_lo;
      s2_prod_hi_r <= prod_hi;
      s2_trans_r   <= mat_r[aat_pkg::ROW_TRANS];
      s2_clip_r    <= crn_clip;
    end
    if (s2_v_r && s3_rdy) begin
      s3_min_r   <= min_term;
      s3_max_r   <= max_term;
      s3_trans_r <= s2_trans_r;
      s3_clip_r  <= s2_clip_r;
    end
    if (s3_v_r && s4_rdy) begin
      for (int j = 0; j < NA; j++) begin
        s4_lo_r[j] <= ext_lo[j].val;
        s4_hi_r[j] <= ext_hi[j].val;
      end
      s4_clip_r <= s3_clip_r | ext_clip;
    end
    if (s4_v_r && out_rdy) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= s4_clip_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

[rtl/aat_checker.sv]
// Port-level checks on the box transform
module aat_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [aat_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out_ payload changed while stalled");

  // A free output side never back-pressures the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // No result can appear before five stages have been filled
  a_rst_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid
                         ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result appeared faster than the pipeline depth");

  // A box transaction is the only source of results: tie in_tuser to use
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tuser))
    else $error("in_tuser unknown on accepted transaction");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/aat_box_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the box transform, keeps its own copy of the
// matrix and checks every world box against the predicted one.
module aat_box_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // row_index, row_x, row_y, row_z, box_center_x/y/z, box_half_x/y/z, pad
  input  logic [aat_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // world_center_x/y/z, world_half_x/y/z, pad
  input  logic [aat_pkg::OUT_TDATA_W-1:0] out_tdata,
  // saturated
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             outstanding,
  output int                             boxes_checked,
  output int                             sat_results,
  output int                             rows_loaded
);

  localparam longint WORD_MAX = 2147483647;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam int     NAX      = aat_pkg::NUM_AXES;

  typedef struct packed {
    logic [2:0][aat_pkg::WORD_W-1:0] center;
    logic [2:0][aat_pkg::HALF_W-1:0] half;
    logic                            saturated;
  } world_box_t;

  // Matrix copy, row-major, sign-extended
  longint     coef [aat_pkg::NUM_ROWS*NAX];
  world_box_t expected_boxes [$];

  // Clamp to the signed word range, noting any clipping
  function automatic longint clip_word(input longint v, inout bit clip);
    if (v > WORD_MAX) begin
      clip = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clip = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // Eight corners through p*M + t, then per-axis extremes
  function automatic world_box_t transform_box(input aat_pkg::in_data_t item);
    longint     mid [3];
    longint     ext [3];
    longint     pt  [3];
    longint     lo  [3];
    longint     hi  [3];
    longint     acc;
    bit         clip;
    world_box_t box;
    mid[0] = longint'($signed(item.box_center_x));
    mid[1] = longint'($signed(item.box_center_y));
    mid[2] = longint'($signed(item.box_center_z));
    ext[0] = longint'(item.box_half_x);
    ext[1] = longint'(item.box_half_y);
    ext[2] = longint'(item.box_half_z);
    clip   = 1'b0;
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < NAX; i++) begin
        pt[i] = clip_word(k[i] ? mid[i] + ext[i] : mid[i] - ext[i], clip);
      end
      for (int j = 0; j < NAX; j++) begin
        acc = coef[aat_pkg::ROW_TRANS*NAX + j];
        // round each product: add half an LSB, then floor shift
        for (int i = 0; i < NAX; i++) begin
          acc += (pt[i] * coef[i*NAX + j]
                  + (longint'(1) <<< (aat_pkg::FRAC_BITS - 1)))
                 >>> aat_pkg::FRAC_BITS;
        end
        acc = clip_word(acc, clip);
        if (k == 0 || acc < lo[j]) lo[j] = acc;
        if (k == 0 || acc > hi[j]) hi[j] = acc;
      end
    end
    for (int j = 0; j < NAX; j++) begin
      box.center[j] = aat_pkg::WORD_W'((lo[j] + hi[j]) >>> 1);
      box.half[j]   = aat_pkg::HALF_W'((hi[j] - lo[j]) >>> 1);
    end
    box.saturated = clip;
    return box;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Both channels sampled at the rising edge
  always @(posedge clk) begin : monitor
    aat_pkg::in_data_t  item;
    aat_pkg::out_data_t res;
    world_box_t         got;
    world_box_t         want;
    if (!rst_n) begin
      foreach (coef[n]) coef[n] = 0;
      expected_boxes.delete();
    end else begin
      // result transaction: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        res           = out_tdata;
        got.center[0] = res.world_center_x;
        got.center[1] = res.world_center_y;
        got.center[2] = res.world_center_z;
        got.half[0]   = res.world_half_x;
        got.half[1]   = res.world_half_y;
        got.half[2]   = res.world_half_z;
        got.saturated = out_tuser;
        if (expected_boxes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_boxes.pop_front();
          boxes_checked++;
          if (want.saturated) sat_results++;
          check_field("world_center_x", want.center[0], got.center[0]);
          check_field("world_center_y", want.center[1], got.center[1]);
          check_field("world_center_z", want.center[2], got.center[2]);
          check_field("world_half_x", {1'b0, want.half[0]}, {1'b0, got.half[0]});
          check_field("world_half_y", {1'b0, want.half[1]}, {1'b0, got.half[1]});
          check_field("world_half_z", {1'b0, want.half[2]}, {1'b0, got.half[2]});
          check_field("saturated", {31'b0, want.saturated}, {31'b0, got.saturated});
        end
      end
      // input transaction: load a row or predict a box
      if (in_tvalid && in_tready) begin
        item = in_tdata;
        if (in_tuser == aat_pkg::KIND_ROW_LOAD) begin
          coef[item.row_index*NAX + 0] = longint'($signed(item.row_x));
          coef[item.row_index*NAX + 1] = longint'($signed(item.row_y));
          coef[item.row_index*NAX + 2] = longint'($signed(item.row_z));
          rows_loaded++;
        end else begin
          expected_boxes.push_back(transform_box(item));
        end
      end
    end
    outstanding = expected_boxes.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int          RANDOM_ITEMS = 1200;
  localparam int          MAX_GAP      = 16;
  localparam int          FB           = aat_pkg::FRAC_BITS;
  localparam logic [31:0] Q_ONE        = 32'(1) << FB;
  localparam logic [31:0] W_MIN        = 32'h8000_0000;
  localparam logic [31:0] W_MAX        = 32'h7FFF_FFFF;
  localparam logic [30:0] H_MAX        = 31'h7FFF_FFFF;

  // value styles for random matrices and boxes
  localparam int STYLE_FULL  = 0;
  localparam int STYLE_SMALL = 1;
  localparam int STYLE_MID   = 2;
  localparam int STYLE_EDGE  = 3;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [aat_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [aat_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  int fail_count;
  int outstanding;
  int boxes_checked;
  int sat_results;
  int rows_loaded;
  int items_sent;
  bit in_quiet;
  bit out_quiet;

  aabb_affine_transform i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  aat_box_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .boxes_checked (boxes_checked),
    .sat_results   (sat_results),
    .rows_loaded   (rows_loaded)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  function automatic logic [31:0] rand_word(input int style);
    case (style)
      STYLE_SMALL: return 32'($urandom_range(0, 8 << FB)) - (32'(4) << FB);
      STYLE_MID:   return 32'($signed($urandom()) >>> 8);
      STYLE_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return W_MIN;
          1:       return W_MAX;
          2:       return 32'h0;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h1;
          default: return Q_ONE;
        endcase
      end
      default:     return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_half(input int style);
    case (style)
      STYLE_SMALL: return 31'($urandom_range(0, 4 << FB));
      STYLE_MID:   return 31'($urandom_range(0, 1 << 23));
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 31'h0;
          1:       return 31'h1;
          2:       return H_MAX;
          3:       return 31'h4000_0000;
          default: return Q_ONE[30:0];
        endcase
      end
      default:     return 31'($urandom());
    endcase
  endfunction

  // One input transaction; valid stays high across back-to-back items
  task automatic send_item(input logic kind, input aat_pkg::in_data_t pkt);
    int gap;
    bit accepted;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pkt;
    do begin
      @(posedge clk);
      accepted = in_tready;
      @(negedge clk);
    end while (!accepted);
    items_sent++;
  endtask

  // Row load; box fields carry noise
  task automatic load_row(input logic [1:0] idx, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
    aat_pkg::in_data_t pkt;
    pkt              = '0;
    pkt.row_index    = idx;
    pkt.row_x        = x;
    pkt.row_y        = y;
    pkt.row_z        = z;
    pkt.box_center_x = $urandom();
    pkt.box_center_y = $urandom();
    pkt.box_center_z = $urandom();
    pkt.box_half_x   = 31'($urandom());
    pkt.box_half_y   = 31'($urandom());
    pkt.box_half_z   = 31'($urandom());
    send_item(aat_pkg::KIND_ROW_LOAD, pkt);
  endtask

  // Box; row fields carry noise
  task automatic send_box(input logic [31:0] cx, input logic [31:0] cy,
                          input logic [31:0] cz, input logic [30:0] hx,
                          input logic [30:0] hy, input logic [30:0] hz);
    aat_pkg::in_data_t pkt;
    pkt              = '0;
    pkt.row_index    = 2'($urandom());
    pkt.row_x        = $urandom();
    pkt.row_y        = $urandom();
    pkt.row_z        = $urandom();
    pkt.box_center_x = cx;
    pkt.box_center_y = cy;
    pkt.box_center_z = cz;
    pkt.box_half_x   = hx;
    pkt.box_half_y   = hy;
    pkt.box_half_z   = hz;
    send_item(aat_pkg::KIND_BOX, pkt);
  endtask

  // Result side: random stall before each result transaction
  initial begin : drain_results
    int stall;
    bit taken;
    out_tready = 1'b0;
    forever begin
      stall = pick_gap(out_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(posedge clk);
        taken = out_tvalid;
        @(negedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    int mat_style;
    int box_style;
    int style;
    int burst;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = aat_pkg::KIND_ROW_LOAD;
    in_tdata  = '0;
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // cleared matrix: everything maps to zero, corner clipping still flags
    send_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
    send_box(W_MIN, W_MAX, 32'h5, H_MAX, H_MAX, 31'h0);

    // identity
    load_row(2'd0, Q_ONE, 32'h0, 32'h0);
    load_row(2'd1, 32'h0, Q_ONE, 32'h0);
    load_row(2'd2, 32'h0, 32'h0, Q_ONE);
    load_row(2'd3, 32'h0, 32'h0, 32'h0);
    send_box(32'h0002_8000, 32'hFFFD_0000, 32'h0000_4000, 31'h1_0000, 31'h8000, 31'h3_0000);
    send_box(W_MAX, W_MIN, 32'h0, H_MAX, 31'h1, 31'h0);

    // quarter turn with mirrored z and an offset
    load_row(2'd0, 32'h0, Q_ONE, 32'h0);
    load_row(2'd1, -Q_ONE, 32'h0, 32'h0);
    load_row(2'd2, 32'h0, 32'h0, -Q_ONE);
    load_row(2'd3, 32'h0003_0000, 32'hFFFB_0000, 32'h7);
    send_box(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 31'h2_0000, 31'h1, 31'h0);

    // extreme coefficients: sums run past the word range
    load_row(2'd0, W_MAX, W_MIN, 32'hFFFF_FFFF);
    load_row(2'd1, W_MIN, W_MAX, 32'h1);
    load_row(2'd2, W_MAX, W_MAX, W_MIN);
    load_row(2'd3, W_MAX, W_MIN, 32'h0);
    send_box(W_MAX, W_MIN, W_MAX, H_MAX, H_MAX, H_MAX);
    send_box(Q_ONE, -Q_ONE, 32'h0, 31'h0, 31'h0, 31'h0);

    // offset cleared: a small box against the extreme coefficients still loaded
    load_row(2'd3, 32'h0, 32'h0, 32'h0);
    send_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 31'h1, 31'h1, 31'h8000);

    // random phases: fresh matrix, then mostly boxes with some row reloads
    while (items_sent < RANDOM_ITEMS + 24) begin
      mat_style = $urandom_range(STYLE_FULL, STYLE_EDGE);
      box_style = $urandom_range(STYLE_FULL, STYLE_EDGE);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < aat_pkg::NUM_ROWS; r++) begin
        load_row(2'(r), rand_word(mat_style), rand_word(mat_style), rand_word(mat_style));
      end
      burst = $urandom_range(40, 120);
      for (int n = 0; n < burst; n++) begin
        style = ($urandom_range(0, 9) < 7) ? box_style : $urandom_range(STYLE_FULL, STYLE_EDGE);
        if ($urandom_range(0, 9) == 0) begin
          load_row(2'($urandom()), rand_word(style), rand_word(style), rand_word(style));
        end else begin
          send_box(rand_word(style), rand_word(style), rand_word(style),
                   rand_half(style), rand_half(style), rand_half(style));
        end
      end
    end
    in_tvalid <= 1'b0;
    in_quiet  = 1'b0;
    out_quiet = 1'b0;

    // let the pipeline empty
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Covered %0d row loads and %0d boxes (%0d with clipping),",
             rows_loaded, boxes_checked, sat_results);
    $display("with random gaps and stalls on both channels between bursts.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/aat_pkg.sv
rtl/aat_col_range.sv
rtl/aabb_affine_transform.sv
rtl/aat_checker.sv
verif/aat_box_checker.sv
verif/testbench.sv
